// File: src/dnh_pkg.sv
package dnh_pkg;

    // Longest name that is hashed; bytes past it are dropped
    localparam logic [7:0] MAX_NAME_LEN = 8'd255;

    // Bytes per half-MD4 block, as a mask of the block start
    localparam logic [7:0] BLK_START_MASK = 8'hE0;

    // Index of the last round of a transform
    localparam logic [4:0] LAST_ROUND = 5'd23;

    // Default chaining value, used when the seed is all zero
    localparam logic [31:0] MD4_IV [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    // Round groups of the transform
    localparam logic [1:0] GRP_SEL = 2'd0;
    localparam logic [1:0] GRP_MAJ = 2'd1;
    localparam logic [1:0] GRP_XOR = 2'd2;

    localparam logic [31:0] K_MAJ = 32'h5A827999;
    localparam logic [31:0] K_XOR = 32'h6ED9EBA1;

    // Message word taken in each round
    localparam logic [2:0] MSG_ORDER [24] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
        3'd1, 3'd3, 3'd5, 3'd7, 3'd0, 3'd2, 3'd4, 3'd6,
        3'd3, 3'd7, 3'd2, 3'd6, 3'd1, 3'd5, 3'd0, 3'd4
    };

    // Rotate amount, indexed by {group, step[1:0]}
    localparam logic [4:0] ROT_AMT [12] = '{
        5'd3, 5'd7, 5'd11, 5'd19,
        5'd3, 5'd5, 5'd9,  5'd13,
        5'd3, 5'd9, 5'd11, 5'd15
    };

    // Pad word built from the bytes left in the current block
    function automatic logic [31:0] dnh_pad(logic [7:0] eff, logic [7:0] seen);
        logic [31:0] rem;
        logic [31:0] half;
        begin
            rem  = {24'd0, eff} - {24'd0, seen & BLK_START_MASK};
            half = rem | (rem << 8);
            return half | (half << 16);
        end
    endfunction

    // Versions 1, 2 (signed) and 4, 5 (unsigned) use half-MD4
    function automatic logic dnh_is_md4(logic [7:0] mode);
        begin
            return (mode == 8'd1) || (mode == 8'd2) || (mode == 8'd4) || (mode == 8'd5);
        end
    endfunction

    // Bytes are sign-extended only below version 3
    function automatic logic dnh_is_signed(logic [7:0] mode);
        begin
            return mode < 8'd3;
        end
    endfunction

endpackage

// File: src/dnh_pack.sv
module dnh_pack
(
    input  logic [7:0]  name_byte,
    input  logic [7:0]  hash_mode,
    input  logic [7:0]  eff_len,
    input  logic [7:0]  seen,
    input  logic [31:0] acc_word,
    input  logic [31:0] mul_sum,
    output logic [31:0] acc_out,
    output logic [31:0] mul_out
);

    logic [31:0] base;
    logic [31:0] byte_ext;

    // A new word starts from the pad, then bytes shift in from the right
    assign base = (seen[1:0] == 2'd0) ? dnh_pkg::dnh_pad(eff_len, seen) : acc_word;

    assign byte_ext = (dnh_pkg::dnh_is_signed(hash_mode) && name_byte[7])
                      ? {24'hFFFFFF, name_byte} : {24'd0, name_byte};

    assign acc_out = byte_ext + {base[23:0], 8'd0};

    // h*33 + byte over unsigned bytes
    assign mul_out = (mul_sum << 5) + mul_sum + {24'd0, name_byte};

endmodule

// File: src/dnh_round.sv
module dnh_round
(
    input  logic [4:0]  rnd,
    input  logic [31:0] v_a,
    input  logic [31:0] v_x,
    input  logic [31:0] v_y,
    input  logic [31:0] v_z,
    input  logic [31:0] msg_word,
    output logic [31:0] r_out
);

    logic [1:0]  grp;
    logic [31:0] fval;
    logic [31:0] kval;
    logic [31:0] sum;
    logic [4:0]  amt;
    logic [63:0] dbl;

    assign grp = rnd[4:3];

    // Round function and constant of the current group
    always_comb
    begin
        case (grp)
            dnh_pkg::GRP_SEL:
            begin
                fval = v_z ^ (v_x & (v_y ^ v_z));
                kval = 32'd0;
            end
            dnh_pkg::GRP_MAJ:
            begin
                fval = (v_x & v_y) + ((v_x ^ v_y) & v_z);
                kval = dnh_pkg::K_MAJ;
            end
            dnh_pkg::GRP_XOR:
            begin
                fval = v_x ^ v_y ^ v_z;
                kval = dnh_pkg::K_XOR;
            end
            default:
            begin
                fval = v_x ^ v_y ^ v_z;
                kval = dnh_pkg::K_XOR;
            end
        endcase
    end

    assign sum = v_a + fval + msg_word + kval;
    assign amt = dnh_pkg::ROT_AMT[{grp, rnd[1:0]}];

    // Rotate left
    assign dbl   = {sum, sum} << amt;
    assign r_out = dbl[63:32];

endmodule

// File: src/directory_name_hash_half_md4.sv
// Directory name hash: a name enters one byte per beat and the beat marked
// last_byte returns one 32-bit hash with bit 0 clear. Versions 1, 2, 4 and 5
// run half-MD4 over 32-byte blocks (1 and 2 sign-extend bytes), chained from
// the seed registers or from the MD4 constants when the seed is all zero;
// other versions give h*33+byte. Seeds must be written while the block is
// idle. A byte is taken whenever the block is idle. A byte that closes a
// 32-byte block holds the input through its transform (24 rounds, then the
// chain add), because one round unit does one round per cycle. The last byte
// pads any open block, runs its transform and then loads the result;
// a result still waiting on out_stall holds the input only once the next
// name's hash is ready to load.
module directory_name_hash_half_md4
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  name_byte,
    input  logic [7:0]  name_len,
    input  logic [7:0]  hash_mode,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] hash_value
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_ROUND,
        S_ADD,
        S_DONE
    } state_t;

    state_t      state_reg, state_next;
    logic [4:0]  rnd_reg, rnd_next;
    logic [2:0]  w_reg, w_next;
    logic        part_reg, part_next;
    logic        fin_reg, fin_next;
    logic        sel_reg, sel_next;
    logic [7:0]  eff_reg, eff_next;
    logic [7:0]  bs_reg, bs_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] msum_reg, msum_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] hash_reg, hash_next;

    logic [31:0] seed_reg [4];
    logic [31:0] chain_reg [4];
    logic [31:0] work_reg [4];
    logic [31:0] msg_reg [8];

    logic        accept;
    logic [7:0]  eff;
    logic        take;
    logic        chain_load;
    logic        seed_zero;
    logic        work_load;
    logic        msg_we;
    logic [2:0]  msg_waddr;
    logic [31:0] msg_wdata;
    logic [31:0] pack_acc;
    logic [31:0] pack_mul;
    logic [31:0] round_out;
    logic [31:0] result;

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

    assign accept    = in_valid && !in_stall;
    assign eff       = (name_len < dnh_pkg::MAX_NAME_LEN) ? name_len : dnh_pkg::MAX_NAME_LEN;
    assign take      = bs_reg < eff;
    assign seed_zero = ((seed_reg[0] | seed_reg[1] | seed_reg[2] | seed_reg[3]) == 32'd0);
    assign result    = sel_reg ? chain_reg[1] : msum_reg;

    // Byte packing and multiplicative sum
    dnh_pack u_pack
    (
        .name_byte (name_byte),
        .hash_mode (hash_mode),
        .eff_len   (eff),
        .seen      (bs_reg),
        .acc_word  (acc_reg),
        .mul_sum   (msum_reg),
        .acc_out   (pack_acc),
        .mul_out   (pack_mul)
    );

    // Shared round unit; slot 0 is always the word being updated
    dnh_round u_round
    (
        .rnd      (rnd_reg),
        .v_a      (work_reg[0]),
        .v_x      (work_reg[1]),
        .v_y      (work_reg[2]),
        .v_z      (work_reg[3]),
        .msg_word (msg_reg[dnh_pkg::MSG_ORDER[rnd_reg]]),
        .r_out    (round_out)
    );

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        rnd_next       = rnd_reg;
        w_next         = w_reg;
        part_next      = part_reg;
        fin_next       = fin_reg;
        sel_next       = sel_reg;
        eff_next       = eff_reg;
        bs_next        = bs_reg;
        acc_next       = acc_reg;
        msum_next      = msum_reg;
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg && out_stall;
        chain_load     = 1'b0;
        work_load      = 1'b0;
        msg_we         = 1'b0;
        msg_waddr      = w_reg;
        msg_wdata      = part_reg ? acc_reg : dnh_pkg::dnh_pad(eff_reg, bs_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    chain_load = (bs_reg == 8'd0) && (take || last_byte);
                    if (take)
                    begin
                        acc_next  = pack_acc;
                        msum_next = pack_mul;
                        bs_next   = 8'(bs_reg + 8'd1);
                        if (bs_reg[1:0] == 2'd3)
                        begin
                            msg_we    = 1'b1;
                            msg_waddr = bs_reg[4:2];
                            msg_wdata = pack_acc;
                        end
                    end
                    if (last_byte)
                    begin
                        fin_next = 1'b1;
                        sel_next = dnh_pkg::dnh_is_md4(hash_mode);
                        eff_next = eff;
                    end
                    if (take && (bs_next[4:0] == 5'd0))
                    begin
                        state_next = S_ROUND;
                        rnd_next   = 5'd0;
                        work_load  = 1'b1;
                    end
                    else if (last_byte && (bs_next[4:0] != 5'd0))
                    begin
                        state_next = S_FILL;
                        w_next     = bs_next[4:2];
                        part_next  = (bs_next[1:0] != 2'd0);
                    end
                    else if (last_byte)
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            // Close the open block: partial word if any, then pad words
            S_FILL:
            begin
                msg_we    = 1'b1;
                part_next = 1'b0;
                w_next    = 3'(w_reg + 3'd1);
                if (w_reg == 3'd7)
                begin
                    state_next = S_ROUND;
                    rnd_next   = 5'd0;
                    work_load  = 1'b1;
                end
            end

            S_ROUND:
            begin
                rnd_next = 5'(rnd_reg + 5'd1);
                if (rnd_reg == dnh_pkg::LAST_ROUND)
                begin
                    state_next = S_ADD;
                end
            end

            S_ADD:
            begin
                state_next = fin_reg ? S_DONE : S_IDLE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    hash_next      = {result[31:1], 1'b0};
                    bs_next        = 8'd0;
                    acc_next       = 32'd0;
                    msum_next      = 32'd0;
                    fin_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, counters and output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rnd_reg       <= 5'd0;
            w_reg         <= 3'd0;
            part_reg      <= 1'b0;
            fin_reg       <= 1'b0;
            sel_reg       <= 1'b0;
            eff_reg       <= 8'd0;
            bs_reg        <= 8'd0;
            acc_reg       <= 32'd0;
            msum_reg      <= 32'd0;
            out_valid_reg <= 1'b0;
            hash_reg      <= 32'd0;
        end
        else
        begin
            state_reg     <= state_next;
            rnd_reg       <= rnd_next;
            w_reg         <= w_next;
            part_reg      <= part_next;
            fin_reg       <= fin_next;
            sel_reg       <= sel_next;
            eff_reg       <= eff_next;
            bs_reg        <= bs_next;
            acc_reg       <= acc_next;
            msum_reg      <= msum_next;
            out_valid_reg <= out_valid_next;
            hash_reg      <= hash_next;
        end
    end

    // Seed registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                seed_reg[i] <= 32'd0;
            end
        end
        else if (cfg_wr_en)
        begin
            seed_reg[cfg_index] <= cfg_data;
        end
    end

    // Chain, working words and message words
    always_ff @(posedge clk)
    begin
        if (chain_load)
        begin
            for (int i = 0; i < 4; i++)
            begin
                chain_reg[i] <= seed_zero ? dnh_pkg::MD4_IV[i] : seed_reg[i];
            end
        end
        else if (state_reg == S_ADD)
        begin
            for (int i = 0; i < 4; i++)
            begin
                chain_reg[i] <= chain_reg[i] + work_reg[i];
            end
        end

        // Words rotate one slot per round; after 24 rounds they are home again
        if (work_load)
        begin
            for (int i = 0; i < 4; i++)
            begin
                work_reg[i] <= chain_reg[i];
            end
        end
        else if (state_reg == S_ROUND)
        begin
            work_reg[0] <= work_reg[3];
            work_reg[1] <= round_out;
            work_reg[2] <= work_reg[1];
            work_reg[3] <= work_reg[2];
        end

        if (msg_we)
        begin
            msg_reg[msg_waddr] <= msg_wdata;
        end
    end

    // Round counter walks 0..23 without a gap
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) && (rnd_reg != dnh_pkg::LAST_ROUND)
        |=> (state_reg == S_ROUND) && (rnd_reg == 5'($past(rnd_reg) + 5'd1)))
        else $error("round counter skipped");

    // A transform runs only on a full block or on the closing block
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> (bs_reg[4:0] == 5'd0) || fin_reg)
        else $error("transform on an open block");

    // Padding always ends with the last message word, then the rounds start
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) && (w_reg == 3'd7) |=> (state_reg == S_ROUND) && (rnd_reg == 5'd0))
        else $error("fill did not hand over to the rounds");

    // Delivering a result clears the per-name state
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && (!out_valid_reg || !out_stall)
        |=> out_valid_reg && (bs_reg == 8'd0) && (msum_reg == 32'd0) && !fin_reg)
        else $error("name state not cleared after result");

    // A pending result is never overwritten by the next name
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && (hash_reg == $past(hash_reg)))
        else $error("pending result lost");

endmodule

// File: sim/name_hash_checker.sv
// Watches the seed port and both beat channels, keeps its own copy of the
// name hash state and checks every returned hash against the oldest one due.
module name_hash_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  name_byte,
    input  logic [7:0]  name_len,
    input  logic [7:0]  hash_mode,
    input  logic        last_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] hash_value,
    input  logic        run_done,
    output int          fail_count,
    output int          pending
);

    // MD4 starting chain, used when all seed words are zero
    localparam logic [31:0] MD4_START [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    // Additive constant per round group: none, sqrt(2), sqrt(3)
    localparam logic [31:0] GROUP_K [3] = '{32'h00000000, 32'h5A827999, 32'h6ED9EBA1};

    // Message word per step, group by group
    localparam int WORD_ORDER [24] = '{
        0, 1, 2, 3, 4, 5, 6, 7,
        1, 3, 5, 7, 0, 2, 4, 6,
        3, 7, 2, 6, 1, 5, 0, 4
    };

    // Left rotate per step within a group
    localparam int ROT_LEFT [12] = '{
        3, 7, 11, 19,
        3, 5, 9,  13,
        3, 9, 11, 15
    };

    // Mode decoding: 3 and up take unsigned bytes and drop by 3
    localparam logic [7:0] UNSIGNED_FROM = 8'd3;
    localparam logic [7:0] VER_HALF_MD4  = 8'd1;
    localparam logic [7:0] VER_TEA       = 8'd2;

    localparam logic [31:0] MUL_FACTOR = 32'd33;
    localparam int          MAX_PRINTS = 100;

    logic [31:0] seed_q [4];
    logic [31:0] chain_q [4];
    logic [31:0] words_q [8];
    logic [31:0] acc_q;
    logic [31:0] seen_q;
    logic [31:0] mul_sum_q;
    logic [31:0] expected_hashes [$];
    logic [31:0] want_hash;
    bit          drain_checked;

    task automatic report_error(input string msg);
        begin
            if (fail_count < MAX_PRINTS)
                $display("%0t checker: %s", $time, msg);
            fail_count++;
        end
    endtask

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
        begin
            return (v << s) | (v >> (32 - s));
        end
    endfunction

    // Pad word: bytes left from the start of the current block, in every lane
    function automatic logic [31:0] block_pad(input logic [31:0] eff, input logic [31:0] seen);
        logic [31:0] rem;
        logic [31:0] half;
        begin
            rem  = eff - (seen & ~32'd31);
            half = rem | (rem << 8);
            return half | (half << 16);
        end
    endfunction

    task automatic load_chain();
        int i;
        begin
            for (i = 0; i < 4; i++)
                chain_q[i] = (seed_q[0] | seed_q[1] | seed_q[2] | seed_q[3]) != 32'd0 ?
                             seed_q[i] : MD4_START[i];
        end
    endtask

    // 24-step half-MD4 over words_q, folded into the chain
    task automatic compress_block();
        logic [31:0] r [4];
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] f;
        int          g;
        int          i;
        int          t;
        begin
            for (i = 0; i < 4; i++)
                r[i] = chain_q[i];
            for (g = 0; g < 3; g++)
            begin
                for (i = 0; i < 8; i++)
                begin
                    // steps update a, d, c, b in turn
                    t = (4 - (i & 3)) & 3;
                    x = r[(t + 1) & 3];
                    y = r[(t + 2) & 3];
                    z = r[(t + 3) & 3];
                    case (g)
                        0:       f = z ^ (x & (y ^ z));
                        1:       f = (x & y) + ((x ^ y) & z);
                        default: f = x ^ y ^ z;
                    endcase
                    r[t] = rotl32(r[t] + f + words_q[WORD_ORDER[g * 8 + i]] + GROUP_K[g],
                                  ROT_LEFT[g * 4 + (i & 3)]);
                end
            end
            for (i = 0; i < 4; i++)
                chain_q[i] = chain_q[i] + r[i];
        end
    endtask

    task automatic clear_name();
        int i;
        begin
            for (i = 0; i < 8; i++)
                words_q[i] = 32'd0;
            acc_q     = 32'd0;
            seen_q    = 32'd0;
            mul_sum_q = 32'd0;
        end
    endtask

    // One accepted name beat; a last beat queues the hash it closes
    task automatic hash_beat(input logic [7:0] b, input logic [7:0] len,
                             input logic [7:0] mode, input logic last);
        logic        uns;
        logic [7:0]  ver;
        logic [31:0] eff;
        logic [31:0] bv;
        logic [31:0] pad;
        logic [31:0] res;
        int          w;
        begin
            uns = mode >= UNSIGNED_FROM;
            ver = uns ? mode - UNSIGNED_FROM : mode;
            // an 8-bit length never exceeds the 255-byte cap
            eff = {24'd0, len};

            // bytes at or past the length are dropped by both hashes
            if (seen_q < eff)
            begin
                bv = (!uns && b[7]) ? {24'hFFFFFF, b} : {24'd0, b};
                if (seen_q == 32'd0)
                    load_chain();
                pad = block_pad(eff, seen_q);
                if (seen_q[1:0] == 2'd0)
                    acc_q = pad;
                acc_q = bv + (acc_q << 8);
                if (seen_q[1:0] == 2'd3)
                    words_q[seen_q[4:2]] = acc_q;
                mul_sum_q = mul_sum_q * MUL_FACTOR + {24'd0, b};
                seen_q    = seen_q + 32'd1;
                if (seen_q[4:0] == 5'd0)
                    compress_block();
            end

            if (last)
            begin
                if (seen_q == 32'd0)
                    load_chain();
                // close the open block: partial word if any, then pad words
                if (seen_q[4:0] != 5'd0)
                begin
                    w   = int'(seen_q[4:2]);
                    pad = block_pad(eff, seen_q);
                    if (seen_q[1:0] != 2'd0)
                    begin
                        words_q[w] = acc_q;
                        w++;
                    end
                    while (w < 8)
                    begin
                        words_q[w] = pad;
                        w++;
                    end
                    compress_block();
                end
                res = (ver == VER_HALF_MD4 || ver == VER_TEA) ? chain_q[1] : mul_sum_q;
                expected_hashes.push_back(res & ~32'd1);
                clear_name();
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_q = '{32'd0, 32'd0, 32'd0, 32'd0};
            load_chain();
            clear_name();
            expected_hashes.delete();
        end
        else
        begin
            // result beat against the oldest hash due
            if (out_valid && !out_stall)
            begin
                if (expected_hashes.size() == 0)
                    report_error($sformatf("hash %h with none due", hash_value));
                else
                begin
                    want_hash = expected_hashes.pop_front();
                    if (hash_value !== want_hash)
                        report_error($sformatf("hash_value %h, want %h", hash_value, want_hash));
                end
            end

            if (cfg_wr_en)
                seed_q[cfg_index] = cfg_data;

            if (in_valid && !in_stall)
                hash_beat(name_byte, name_len, hash_mode, last_byte);

            if (run_done && !drain_checked)
            begin
                drain_checked = 1'b1;
                if (expected_hashes.size() != 0)
                    report_error($sformatf("%0d hashes never returned", expected_hashes.size()));
            end
        end
        pending = expected_hashes.size();
    end

endmodule

// File: sim/tb_directory_name_hash_half_md4.sv
module tb_directory_name_hash_half_md4;

    // Seed register indexes
    localparam logic [1:0] SEED_W0 = 2'd0;
    localparam logic [1:0] SEED_W1 = 2'd1;
    localparam logic [1:0] SEED_W2 = 2'd2;
    localparam logic [1:0] SEED_W3 = 2'd3;

    // Hash versions
    localparam logic [7:0] MODE_LEGACY     = 8'd0;
    localparam logic [7:0] MODE_HALF_MD4   = 8'd1;
    localparam logic [7:0] MODE_TEA        = 8'd2;
    localparam logic [7:0] MODE_LEGACY_U   = 8'd3;
    localparam logic [7:0] MODE_HALF_MD4_U = 8'd4;
    localparam logic [7:0] MODE_TEA_U      = 8'd5;
    localparam logic [7:0] MODE_TOP        = 8'd255;

    localparam int NUM_PHASES      = 6;
    localparam int BEATS_PER_PHASE = 270;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_CYCLES     = 300;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  name_byte;
    logic [7:0]  name_len;
    logic [7:0]  hash_mode;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] hash_value;
    logic        run_done;
    int          fail_count;
    int          pending;

    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_req;
    int beats_sent;

    directory_name_hash_half_md4 dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .name_byte  (name_byte),
        .name_len   (name_len),
        .hash_mode  (hash_mode),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_value (hash_value)
    );

    name_hash_checker chk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .name_byte  (name_byte),
        .name_len   (name_len),
        .hash_mode  (hash_mode),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_value (hash_value),
        .run_done   (run_done),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Hard stop in case the block hangs
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold on request
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(0, 8)) @(negedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    function automatic logic [7:0] pick_mode();
        begin
            case ($urandom_range(0, 9))
                0, 1:    return MODE_HALF_MD4;
                2:       return MODE_TEA;
                3, 4:    return MODE_HALF_MD4_U;
                5:       return MODE_TEA_U;
                6:       return MODE_LEGACY;
                7:       return MODE_LEGACY_U;
                default: return 8'($urandom_range(0, 255));
            endcase
        end
    endfunction

    // Mostly short names, some on 32-byte block edges, a few near the cap
    function automatic logic [7:0] pick_len();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                return 8'd0;
            else if (r < 60)
                return 8'($urandom_range(1, 12));
            else if (r < 82)
                return 8'($urandom_range(13, 40));
            else if (r < 90)
                return 8'(31 + $urandom_range(0, 2) + 32 * $urandom_range(0, 2));
            else if (r < 97)
                return 8'($urandom_range(41, 120));
            else
                return 8'($urandom_range(200, 255));
        end
    endfunction

    task automatic idle_in(input int n);
        begin
            repeat (n)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
    endtask

    // One name beat; returns at the edge that takes it, valid still high
    task automatic drive_beat(input logic [7:0] b, input logic [7:0] len,
                              input logic [7:0] mode, input logic last, input bit counted);
        begin
            if (tx_idle_on && $urandom_range(0, 4) == 0)
                idle_in($urandom_range(1, 9));
            @(negedge clk);
            in_valid  <= 1'b1;
            name_byte <= b;
            name_len  <= len;
            hash_mode <= mode;
            last_byte <= last;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            if (counted)
                beats_sent++;
        end
    endtask

    task automatic send_name(input logic [7:0] mode, input logic [7:0] len, input int nbytes,
                             input bit mix_modes, input bit mix_lens);
        logic [7:0] m;
        logic [7:0] l;
        int         k;
        begin
            for (k = 0; k < nbytes; k++)
            begin
                m = mix_modes ? pick_mode() : mode;
                l = (mix_lens && $urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 255)) : len;
                drive_beat(8'($urandom_range(0, 255)), l, m, k == nbytes - 1,
                           (k < int'(l)) || (k == nbytes - 1));
            end
        end
    endtask

    // Drop valid, wait out every hash due, then let a trailing transform finish
    task automatic drain_and_settle();
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (pending != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end
    endtask

    task automatic write_seed(input logic [1:0] idx, input logic [31:0] data);
        begin
            @(negedge clk);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(negedge clk);
            cfg_wr_en <= 1'b0;
        end
    endtask

    initial
    begin
        logic [31:0] s [4];
        logic [7:0]  len;
        int          phase;
        int          goal;
        int          kind;
        int          k;
        bit          quiet;

        rst_n      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = SEED_W0;
        cfg_data   = 32'd0;
        in_valid   = 1'b0;
        name_byte  = 8'd0;
        name_len   = 8'd0;
        hash_mode  = MODE_LEGACY;
        last_byte  = 1'b0;
        run_done   = 1'b0;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_req   = 1'b0;
        beats_sent = 0;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            // seed setting for this phase: zero, all ones, random, lone low bit, top bit
            case (phase)
                1:       s = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
                2:       s = '{$urandom, $urandom, $urandom, $urandom};
                3:       s = '{32'd0, 32'd0, 32'd0, 32'd1};
                4:       s = '{32'h80000000, 32'd0, 32'd0, 32'd0};
                default: s = '{32'd0, 32'd0, 32'd0, 32'd0};
            endcase
            write_seed(SEED_W0, s[0]);
            write_seed(SEED_W1, s[1]);
            write_seed(SEED_W2, s[2]);
            write_seed(SEED_W3, s[3]);

            if (phase == 0)
            begin
                // empty names: straight from seed or constants
                drive_beat(8'hA5, 8'd0, MODE_HALF_MD4, 1'b1, 1'b1);
                drive_beat(8'hFF, 8'd0, MODE_LEGACY, 1'b1, 1'b1);
                // one-byte names, sign extension on and off
                drive_beat(8'hFF, 8'd1, MODE_HALF_MD4, 1'b1, 1'b1);
                drive_beat(8'hFF, 8'd1, MODE_HALF_MD4_U, 1'b1, 1'b1);
                drive_beat(8'h00, 8'd1, MODE_TOP, 1'b1, 1'b1);
                // bytes past the length are dropped
                drive_beat(8'h80, 8'd2, MODE_TEA, 1'b0, 1'b1);
                drive_beat(8'h7F, 8'd2, MODE_TEA, 1'b0, 1'b1);
                drive_beat(8'h55, 8'd2, MODE_TEA, 1'b0, 1'b0);
                drive_beat(8'hAA, 8'd2, MODE_TEA, 1'b1, 1'b1);
                // name ends well short of its length
                drive_beat(8'h01, 8'd255, MODE_TEA_U, 1'b0, 1'b1);
                drive_beat(8'h01, 8'd255, MODE_TEA_U, 1'b0, 1'b1);
                drive_beat(8'hFE, 8'd255, MODE_TEA_U, 1'b1, 1'b1);
                // version 3 is multiplicative over unsigned bytes
                for (k = 0; k < 5; k++)
                    drive_beat(8'hF0 + 8'(k), 8'd5, MODE_LEGACY_U, k == 4, 1'b1);
                // each beat signs its own byte; the last beat picks the hash
                drive_beat(8'hC3, 8'd4, MODE_HALF_MD4, 1'b0, 1'b1);
                drive_beat(8'hC3, 8'd4, MODE_HALF_MD4_U, 1'b0, 1'b1);
                drive_beat(8'hC3, 8'd4, MODE_LEGACY, 1'b0, 1'b1);
                drive_beat(8'hC3, 8'd4, MODE_TEA, 1'b1, 1'b1);
                drive_beat(8'h9C, 8'd3, MODE_HALF_MD4, 1'b0, 1'b1);
                drive_beat(8'h9C, 8'd3, MODE_TEA, 1'b0, 1'b1);
                drive_beat(8'h9C, 8'd3, MODE_LEGACY, 1'b1, 1'b1);
            end

            if (phase == 2)
            begin
                // long result hold while names keep coming, then full drain
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
                hold_req   = 1'b1;
                repeat (8)
                begin
                    len = 8'($urandom_range(1, 10));
                    send_name(pick_mode(), len, int'(len), 1'b0, 1'b0);
                end
                drain_and_settle();
            end

            quiet = (phase == NUM_PHASES - 1);
            goal  = beats_sent + BEATS_PER_PHASE;
            while (beats_sent < goal)
            begin
                tx_idle_on = !quiet && $urandom_range(0, 3) != 0;
                rx_idle_on = !quiet && $urandom_range(0, 3) != 0;
                len  = pick_len();
                kind = $urandom_range(0, 99);
                if (kind < 78)
                    send_name(pick_mode(), len, len == 8'd0 ? 1 : int'(len), 1'b0, 1'b0);
                else if (kind < 86)
                begin
                    // stops short of its length
                    if (len < 8'd2)
                        len = 8'($urandom_range(2, 40));
                    send_name(pick_mode(), len, $urandom_range(1, int'(len) - 1), 1'b0, 1'b0);
                end
                else if (kind < 92)
                    // runs past its length
                    send_name(pick_mode(), len, int'(len) + $urandom_range(1, 6), 1'b0, 1'b0);
                else if (kind < 96)
                    send_name(pick_mode(), len, len == 8'd0 ? 1 : int'(len), 1'b1, 1'b0);
                else
                    // length field changes mid-name
                    send_name(pick_mode(), len, $urandom_range(1, 20), 1'b1, 1'b1);
            end
            drain_and_settle();
        end

        @(negedge clk);
        run_done <= 1'b1;
        repeat (2) @(negedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
